>>> src/spc_pkg.sv
// ============================================================================
// spc_pkg
// Shared types and constants for the social proxemic cost cell.
// ============================================================================
package spc_pkg;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [2:0] REG_FRONT_MAJOR = 3'd0;
  localparam logic [2:0] REG_FRONT_MINOR = 3'd1;
  localparam logic [2:0] REG_REAR_RADIUS = 3'd2;
  localparam logic [2:0] REG_CUTOFF      = 3'd3;
  localparam logic [2:0] REG_ORIGIN_X    = 3'd4;
  localparam logic [2:0] REG_ORIGIN_Y    = 3'd5;
  localparam logic [2:0] REG_CELL_SIZE   = 3'd6;

  typedef enum logic {
    DU_DIV,
    DU_SQRT
  } du_op_e;

  typedef struct packed {
    logic        start;
    du_op_e      op;
    logic [63:0] num;
    logic [63:0] den;
  } du_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } du_rsp_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
  } person_t;

endpackage

>>> src/spc_mul.sv
// ============================================================================
// spc_mul
// Shared signed 33x33 multiplier with registered product.
// ============================================================================
module spc_mul (
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [65:0] p_o
);

  logic signed [65:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

>>> src/spc_divsqrt.sv
// ============================================================================
// spc_divsqrt
// Shared radix-2 restoring divider and digit-by-digit integer square root.
// ============================================================================
module spc_divsqrt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spc_pkg::du_req_t  req_i,
  output spc_pkg::du_rsp_t  rsp_o
);
  import spc_pkg::*;

  logic        busy_q, done_q;
  du_op_e      op_q;
  logic [5:0]  cnt_q;
  logic [63:0] num_q, den_q, quo_q;
  logic [65:0] rem_q;
  logic [65:0] cur, trial;
  logic        ge;

  always_comb begin
    if (op_q == DU_DIV) begin
      cur   = {rem_q[64:0], num_q[63]};
      trial = {2'b00, den_q};
    end else begin
      cur   = {rem_q[63:0], num_q[63:62]};
      trial = {quo_q, 2'b01};
    end
    ge = (cur >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == 6'd0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q  <= req_i.op;
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
      quo_q <= '0;
      cnt_q <= (req_i.op == DU_DIV) ? 6'd63 : 6'd31;
    end else if (busy_q) begin
      rem_q <= ge ? (cur - trial) : cur;
      quo_q <= {quo_q[62:0], ge};
      num_q <= (op_q == DU_DIV) ? {num_q[62:0], 1'b0} : {num_q[61:0], 2'b00};
      cnt_q <= cnt_q - 6'd1;
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = quo_q;

endmodule

>>> src/spc_person_store.sv
// ============================================================================
// spc_person_store
// Person table: one write port, one registered read port.
// ============================================================================
module spc_person_store #(
  parameter int MAX_PERSONS = 32
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [((MAX_PERSONS > 1) ? $clog2(MAX_PERSONS) : 1)-1:0] waddr_i,
  input  spc_pkg::person_t     wdata_i,
  input  logic [((MAX_PERSONS > 1) ? $clog2(MAX_PERSONS) : 1)-1:0] raddr_i,
  output spc_pkg::person_t     rdata_o
);
  import spc_pkg::*;

  person_t mem_q [MAX_PERSONS];
  person_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/social_proxemic_cost_cell.sv
// ============================================================================
// social_proxemic_cost_cell
// Person table with per-cell social cost query (front ellipse, rear circle).
//
//   channel | direction | handshake          | payload
//   in      | sink      | in_valid/in_stall  | command, pos, vel, cell index
//   out     | source    | out_valid/out_stall| cost_percent, status
//   cfg     | sink      | cfg_valid/ready    | cfg_index, cfg_data
//
// Clear and add go straight from idle to the output state. A query walks every
// stored person; a person outside the cutoff is skipped early, and one inside
// it uses the shared divide/square-root unit (64 steps per divide, 32 per
// root). Reset is asynchronous; the table needs no clearing.
// A stalled result is held in the output register while the next item runs.
// ============================================================================
module social_proxemic_cost_cell #(
  parameter int MAX_PERSONS  = 32,
  parameter int MAX_GRID_DIM = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         command_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [15:0] vel_x_i,
  input  logic signed [15:0] vel_y_i,
  input  logic [11:0]        cell_col_i,
  input  logic [11:0]        cell_row_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [6:0]         cost_percent_o,
  output logic               status_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import spc_pkg::*;

  localparam int IdxW = (MAX_PERSONS > 1) ? $clog2(MAX_PERSONS) : 1;
  localparam int CntW = $clog2(MAX_PERSONS + 1);

  typedef enum logic [5:0] {
    S_IDLE, S_CX, S_CY, S_LIM, S_L2, S_RD, S_LD, S_CHK, S_MX, S_MY,
    S_VX2, S_VY2, S_SP, S_NX1, S_NX2, S_DVX, S_NY1, S_NY2, S_DVY, S_SEL,
    S_A2, S_RX2, S_DE1, S_B2, S_RY2, S_DE2,
    S_R2, S_RRX, S_RRY, S_RSQ, S_RDV,
    S_NEXT, S_SCALE, S_ROUND, S_OUT
  } state_e;

  state_e state_q;

  logic [15:0]        major_q, minor_q, radius_q, cutoff_q;
  logic signed [31:0] origin_x_q, origin_y_q;
  logic [31:0]        cell_size_q;

  logic [CntW-1:0]    count_q, idx_q;
  logic [11:0]        col_q, row_q;
  logic signed [47:0] cx2_q, cy2_q;
  logic [49:0]        lim2_q;
  logic signed [49:0] dx2_q, dy2_q;
  logic signed [15:0] vx_q, vy_q;
  logic [51:0]        sq_q;
  logic [23:0]        sp_q;
  logic signed [36:0] t_q;
  logic               neg_q;
  logic signed [23:0] rx_q, ry_q;
  logic [39:0]        a2_q;
  logic [63:0]        e_q;
  logic [16:0]        best_q;
  logic [6:0]         res_cost_q;
  logic               res_status_q;
  logic               out_valid_q;
  logic [6:0]         cost_q;
  logic               status_q;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  du_req_t            du_req;
  du_rsp_t            du_rsp;
  logic               st_we;
  person_t            st_wdata, st_rdata;

  logic [15:0]        major_eff, minor_eff, radius_eff;
  logic signed [49:0] lim_s;
  logic [52:0]        dist_sum;
  logic [31:0]        vsum;
  logic signed [37:0] nsum;
  logic signed [45:0] n46;
  logic [45:0]        nabs;
  logic [47:0]        rsum;
  logic [64:0]        esum;
  logic [16:0]        fcost, rcost;
  logic [24:0]        round_sum;
  logic               in_grid;
  logic               out_free;

  function automatic logic signed [21:0] rnd5(logic signed [49:0] v);
    logic signed [26:0] w;
    w = 27'(v) + 27'sd16;
    return 22'(w >>> 5);
  endfunction

  spc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  spc_divsqrt u_divsqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (du_req),
    .rsp_o  (du_rsp)
  );

  spc_person_store #(
    .MAX_PERSONS (MAX_PERSONS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (st_wdata),
    .raddr_i (idx_q[IdxW-1:0]),
    .rdata_o (st_rdata)
  );

  assign major_eff  = (major_q == 16'd0) ? 16'd1 : major_q;
  assign minor_eff  = (minor_q == 16'd0) ? 16'd1 : minor_q;
  assign radius_eff = (radius_q == 16'd0) ? 16'd1 : radius_q;
  assign lim_s      = {25'd0, cutoff_q, 9'd0};

  assign dist_sum  = 53'(sq_q) + 53'(prod[50:0]);
  assign vsum      = sq_q[31:0] + prod[31:0];
  assign nsum      = (state_q == S_NY2) ? ({t_q[36], t_q} - {prod[36], prod[36:0]})
                                        : ({t_q[36], t_q} + {prod[36], prod[36:0]});
  assign n46       = {nsum, 8'd0};
  assign nabs      = nsum[37] ? 46'(-n46) : 46'(n46);
  assign rsum      = 48'(sq_q[46:0]) + 48'(prod[46:0]);
  assign esum      = {1'b0, e_q} + {1'b0, du_rsp.result};
  assign fcost     = (esum <= 65'h10000) ? 17'(65'h10000 - esum) : 17'd0;
  assign rcost     = (du_rsp.result > 64'h10000) ? 17'd0 : 17'(64'h10000 - du_rsp.result);
  assign round_sum = 25'(prod[23:0]) + 25'd32768;

  assign in_grid  = (32'(cell_col_i) < MAX_GRID_DIM) && (32'(cell_row_i) < MAX_GRID_DIM);
  assign out_free = !out_valid_q || !out_stall_i;

  assign st_we    = (state_q == S_IDLE) && in_valid_i && (command_i == CMD_ADD) &&
                    (count_q != CntW'(MAX_PERSONS));
  assign st_wdata = '{px: pos_x_i, py: pos_y_i, vx: vel_x_i, vy: vel_y_i};

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    du_req = '{start: 1'b0, op: DU_DIV, num: 64'd0, den: 64'd0};
    case (state_q)
      S_CX: begin
        mul_a = {20'd0, col_q, 1'b1};
        mul_b = {1'b0, cell_size_q};
      end
      S_CY: begin
        mul_a = {20'd0, row_q, 1'b1};
        mul_b = {1'b0, cell_size_q};
      end
      S_LIM: begin
        mul_a = {8'd0, cutoff_q, 9'd0};
        mul_b = {8'd0, cutoff_q, 9'd0};
      end
      S_CHK: begin
        mul_a = 33'(dx2_q);
        mul_b = 33'(dx2_q);
      end
      S_MX: begin
        mul_a = 33'(dy2_q);
        mul_b = 33'(dy2_q);
      end
      S_MY: begin
        mul_a = 33'(vx_q);
        mul_b = 33'(vx_q);
      end
      S_VX2: begin
        mul_a = 33'(vy_q);
        mul_b = 33'(vy_q);
      end
      S_VY2: begin
        du_req = '{start: 1'b1, op: DU_SQRT, num: {16'd0, vsum, 16'd0}, den: 64'd0};
      end
      S_SP: begin
        mul_a = 33'(rnd5(dx2_q));
        mul_b = 33'(vx_q);
      end
      S_NX1: begin
        mul_a = 33'(rnd5(dy2_q));
        mul_b = 33'(vy_q);
      end
      S_NX2, S_NY2: begin
        du_req = '{start: 1'b1, op: DU_DIV, num: 64'(nabs) + 64'(sp_q[23:1]),
                   den: 64'(sp_q)};
      end
      S_DVX: begin
        mul_a = 33'(rnd5(dy2_q));
        mul_b = 33'(vx_q);
      end
      S_NY1: begin
        mul_a = 33'(rnd5(dx2_q));
        mul_b = 33'(vy_q);
      end
      S_SEL: begin
        if (!rx_q[23]) begin
          mul_a = {13'd0, major_eff, 4'd0};
          mul_b = {13'd0, major_eff, 4'd0};
        end else begin
          mul_a = {13'd0, radius_eff, 4'd0};
          mul_b = {13'd0, radius_eff, 4'd0};
        end
      end
      S_A2, S_R2: begin
        mul_a = 33'(rx_q);
        mul_b = 33'(rx_q);
      end
      S_RX2, S_RY2: begin
        du_req = '{start: 1'b1, op: DU_DIV, num: {1'b0, prod[46:0], 16'd0},
                   den: {24'd0, a2_q}};
      end
      S_DE1: begin
        mul_a = {13'd0, minor_eff, 4'd0};
        mul_b = {13'd0, minor_eff, 4'd0};
      end
      S_B2, S_RRX: begin
        mul_a = 33'(ry_q);
        mul_b = 33'(ry_q);
      end
      S_RRY: begin
        du_req = '{start: (rsum <= 48'(a2_q)), op: DU_SQRT,
                   num: {8'd0, rsum, 8'd0}, den: 64'd0};
      end
      S_RSQ: begin
        du_req = '{start: du_rsp.done, op: DU_DIV,
                   num: {27'd0, du_rsp.result[24:0], 12'd0},
                   den: {44'd0, radius_eff, 4'd0}};
      end
      S_SCALE: begin
        mul_a = {16'd0, best_q};
        mul_b = 33'd100;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      major_q     <= 16'd640;
      minor_q     <= 16'd256;
      radius_q    <= 16'd205;
      cutoff_q    <= 16'd768;
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      cell_size_q <= 32'd3277;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_FRONT_MAJOR: major_q     <= cfg_data_i[15:0];
          REG_FRONT_MINOR: minor_q     <= cfg_data_i[15:0];
          REG_REAR_RADIUS: radius_q    <= cfg_data_i[15:0];
          REG_CUTOFF:      cutoff_q    <= cfg_data_i[15:0];
          REG_ORIGIN_X:    origin_x_q  <= cfg_data_i;
          REG_ORIGIN_Y:    origin_y_q  <= cfg_data_i;
          REG_CELL_SIZE:   cell_size_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            res_cost_q   <= 7'd0;
            res_status_q <= (command_i == CMD_ADD) && (count_q == CntW'(MAX_PERSONS));
            state_q      <= ((command_i == CMD_QUERY) && in_grid) ? S_CX : S_OUT;
            case (command_i)
              CMD_CLEAR: count_q <= '0;
              CMD_ADD: begin
                if (count_q != CntW'(MAX_PERSONS)) begin
                  count_q <= count_q + 1'b1;
                end
              end
              CMD_QUERY: begin
                col_q  <= cell_col_i;
                row_q  <= cell_row_i;
                best_q <= '0;
              end
              default: ;
            endcase
          end
        end
        S_CX:  state_q <= S_CY;
        S_CY: begin
          cx2_q   <= {{15{origin_x_q[31]}}, origin_x_q, 1'b0} + prod[47:0];
          state_q <= S_LIM;
        end
        S_LIM: begin
          cy2_q   <= {{15{origin_y_q[31]}}, origin_y_q, 1'b0} + prod[47:0];
          idx_q   <= '0;
          state_q <= S_L2;
        end
        S_L2: begin
          lim2_q  <= prod[49:0];
          state_q <= S_RD;
        end
        S_RD: state_q <= (idx_q == count_q) ? S_SCALE : S_LD;
        S_LD: begin
          dx2_q   <= {{2{cx2_q[47]}}, cx2_q} - {{17{st_rdata.px[31]}}, st_rdata.px, 1'b0};
          dy2_q   <= {{2{cy2_q[47]}}, cy2_q} - {{17{st_rdata.py[31]}}, st_rdata.py, 1'b0};
          vx_q    <= st_rdata.vx;
          vy_q    <= st_rdata.vy;
          state_q <= S_CHK;
        end
        S_CHK: begin
          if (dx2_q > lim_s || dx2_q < -lim_s || dy2_q > lim_s || dy2_q < -lim_s) begin
            state_q <= S_NEXT;
          end else begin
            state_q <= S_MX;
          end
        end
        S_MX: begin
          sq_q    <= 52'(prod[50:0]);
          state_q <= S_MY;
        end
        S_MY: begin
          if (dist_sum > 53'(lim2_q)) begin
            state_q <= S_NEXT;
          end else if (vx_q == 16'sd0 && vy_q == 16'sd0) begin
            rx_q    <= 24'(rnd5(dx2_q));
            ry_q    <= 24'(rnd5(dy2_q));
            state_q <= S_SEL;
          end else begin
            state_q <= S_VX2;
          end
        end
        S_VX2: begin
          sq_q    <= 52'(prod[31:0]);
          state_q <= S_VY2;
        end
        S_VY2: state_q <= S_SP;
        S_SP: begin
          if (du_rsp.done) begin
            sp_q    <= du_rsp.result[23:0];
            state_q <= S_NX1;
          end
        end
        S_NX1: begin
          t_q     <= $signed(prod[36:0]);
          state_q <= S_NX2;
        end
        S_NX2: begin
          neg_q   <= nsum[37];
          state_q <= S_DVX;
        end
        S_DVX: begin
          if (du_rsp.done) begin
            rx_q    <= neg_q ? (24'd0 - du_rsp.result[23:0]) : du_rsp.result[23:0];
            state_q <= S_NY1;
          end
        end
        S_NY1: begin
          t_q     <= $signed(prod[36:0]);
          state_q <= S_NY2;
        end
        S_NY2: begin
          neg_q   <= nsum[37];
          state_q <= S_DVY;
        end
        S_DVY: begin
          if (du_rsp.done) begin
            ry_q    <= neg_q ? (24'd0 - du_rsp.result[23:0]) : du_rsp.result[23:0];
            state_q <= S_SEL;
          end
        end
        S_SEL: state_q <= rx_q[23] ? S_R2 : S_A2;
        S_A2: begin
          a2_q    <= prod[39:0];
          state_q <= S_RX2;
        end
        S_RX2: state_q <= S_DE1;
        S_DE1: begin
          if (du_rsp.done) begin
            e_q     <= du_rsp.result;
            state_q <= S_B2;
          end
        end
        S_B2: begin
          a2_q    <= prod[39:0];
          state_q <= S_RY2;
        end
        S_RY2: state_q <= S_DE2;
        S_DE2: begin
          if (du_rsp.done) begin
            if (fcost > best_q) begin
              best_q <= fcost;
            end
            state_q <= S_NEXT;
          end
        end
        S_R2: begin
          a2_q    <= prod[39:0];
          state_q <= S_RRX;
        end
        S_RRX: begin
          sq_q    <= 52'(prod[46:0]);
          state_q <= S_RRY;
        end
        S_RRY: state_q <= (rsum <= 48'(a2_q)) ? S_RSQ : S_NEXT;
        S_RSQ: begin
          if (du_rsp.done) begin
            state_q <= S_RDV;
          end
        end
        S_RDV: begin
          if (du_rsp.done) begin
            if (rcost > best_q) begin
              best_q <= rcost;
            end
            state_q <= S_NEXT;
          end
        end
        S_NEXT: begin
          idx_q   <= idx_q + 1'b1;
          state_q <= S_RD;
        end
        S_SCALE: state_q <= S_ROUND;
        S_ROUND: begin
          res_cost_q <= round_sum[22:16];
          state_q    <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            cost_q      <= res_cost_q;
            status_q    <= res_status_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign cost_percent_o = cost_q;
  assign status_o       = status_q;
  assign cfg_ready_o    = 1'b1;

endmodule
